// File: hw/rtl/assert_macros.svh
// Assertion macros used by the stopwatch core (usw_core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/usw_pkg.sv
// Types, codes and constants shared by the stopwatch modules.
`timescale 1ns / 1ps

package usw_pkg;

	// Saturation limit of the up count, in tenths.
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	// Preset after reset: twelve minutes.
	localparam logic [15:0] PRESET_RESET = 16'd7200;

	// Item kinds carried in tuser.
	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_BUTTONS = 1'b1;

	// Bit positions of the button levels.
	localparam int BTN_START_STOP = 0;
	localparam int BTN_RESET      = 1;
	localparam int BTN_UP         = 2;
	localparam int BTN_DOWN       = 3;

	// Reciprocal constants for the digit split of a 16-bit value.
	localparam logic [16:0] RECIP_600 = 17'd111849;  // 2^26 / 600, rounded up
	localparam int          SHIFT_600 = 26;
	localparam logic [15:0] RECIP_10  = 16'd52429;   // 2^19 / 10, rounded up
	localparam int          SHIFT_10  = 19;

	typedef struct packed {
		logic       command;
		logic [3:0] btn;
	} item_t;

	typedef struct packed {
		logic en;     // pipeline advances this cycle
		logic valid;  // an item sits in the input register
	} ctl_t;

	typedef struct packed {
		logic [15:0] shown;
		logic        up;
		logic        run;
		logic        pin;
	} stat_t;

	typedef struct packed {
		logic [6:0] minutes;
		logic [5:0] seconds;
		logic [3:0] tenths;
		logic       up;
		logic       run;
		logic       pin;
	} disp_t;

endpackage

// File: hw/rtl/usw_core.sv
// Stopwatch state: button edge detection, tick handling and preset register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module usw_core import usw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  ctl_t        ctl,
	input  item_t       item,
	output stat_t       stat_s2
);

	logic [15:0] preset_q;
	logic        running_q, armed_q, up_q, pin_q;
	logic [15:0] elapsed_q, shown_q;
	logic [3:0]  prev_q;

	logic        run_d, armed_d, up_d, pin_d;
	logic [15:0] elapsed_d, shown_d;
	logic [3:0]  prev_d;
	logic [3:0]  rise;
	logic [16:0] next_cnt;

	always_comb begin
		run_d     = running_q;
		armed_d   = armed_q;
		up_d      = up_q;
		pin_d     = pin_q;
		elapsed_d = elapsed_q;
		shown_d   = shown_q;
		prev_d    = prev_q;
		rise      = item.btn & ~prev_q;
		next_cnt  = {1'b0, elapsed_q} + 17'd1;
		if (item.command == CMD_BUTTONS) begin
			// Buttons act in a fixed order within one sample.
			if (rise[BTN_START_STOP]) begin
				armed_d = 1'b0;
				run_d   = !run_d;
			end
			if (rise[BTN_RESET]) begin
				armed_d = 1'b1;
				run_d   = 1'b0;
			end
			if (rise[BTN_UP] && !run_d) begin
				up_d    = 1'b1;
				armed_d = 1'b1;
			end
			if (rise[BTN_DOWN] && !run_d) begin
				up_d    = 1'b0;
				armed_d = 1'b1;
			end
			prev_d = item.btn;
		end else begin
			if (running_q) begin
				pin_d = !pin_q;
				if (up_q) begin
					if (elapsed_q < COUNT_MAX) begin
						elapsed_d = next_cnt[15:0];
					end else begin
						elapsed_d = COUNT_MAX;
					end
					shown_d = elapsed_d;
				end else begin
					// The countdown reloads the preset where it would reach zero.
					if (next_cnt >= {1'b0, preset_q}) begin
						elapsed_d = '0;
						shown_d   = preset_q;
					end else begin
						elapsed_d = next_cnt[15:0];
						shown_d   = preset_q - next_cnt[15:0];
					end
				end
			end else begin
				pin_d = 1'b0;
			end
			if (armed_q) begin
				pin_d     = 1'b0;
				elapsed_d = '0;
				shown_d   = up_q ? 16'd0 : preset_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q <= PRESET_RESET;
		end else if (cfg_we) begin
			preset_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			armed_q   <= 1'b0;
			up_q      <= 1'b1;
			pin_q     <= 1'b0;
			elapsed_q <= '0;
			shown_q   <= '0;
			prev_q    <= '0;
		end else if (ctl.en && ctl.valid) begin
			running_q <= run_d;
			armed_q   <= armed_d;
			up_q      <= up_d;
			pin_q     <= pin_d;
			elapsed_q <= elapsed_d;
			shown_q   <= shown_d;
			prev_q    <= prev_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en && ctl.valid) begin
			stat_s2.shown <= shown_d;
			stat_s2.up    <= up_d;
			stat_s2.run   <= run_d;
			stat_s2.pin   <= pin_d;
		end
	end

	`ASSERT_ALWAYS(a_run_not_armed, clk, arst_n, running_q |-> !armed_q, "running with reset armed")
	`ASSERT_NEXT(a_stop_pin_low, clk, arst_n, ctl.en && ctl.valid && item.command == CMD_TICK && !running_q, !pin_q, "pin not low after a stopped tick")
	`ASSERT_NEXT(a_btn_keeps_shown, clk, arst_n, ctl.en && ctl.valid && item.command == CMD_BUTTONS, $stable(shown_q), "button sample changed shown value")

endmodule

// File: hw/rtl/usw_split.sv
// Two-stage split of the shown value into minutes, seconds and tenths.
`timescale 1ns / 1ps

module usw_split import usw_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  stat_t stat_s2,
	output disp_t disp_s4
);

	logic [32:0] prod600;
	logic [31:0] prod10;
	logic [6:0]  min_s3;
	logic [12:0] q10_s3;
	stat_t       stat_s3;
	logic [12:0] sec_full;
	logic [15:0] ten_full;

	// Reciprocal multiplies; both quotients are exact for any 16-bit value.
	assign prod600 = {17'd0, stat_s2.shown} * {16'd0, RECIP_600};
	assign prod10  = {16'd0, stat_s2.shown} * {16'd0, RECIP_10};

	always_ff @(posedge clk) begin
		if (en) begin
			min_s3  <= prod600[SHIFT_600 + 6:SHIFT_600];
			q10_s3  <= prod10[SHIFT_10 + 12:SHIFT_10];
			stat_s3 <= stat_s2;
		end
	end

	// Remainders by constant multiply and subtract.
	assign sec_full = q10_s3 - ({6'd0, min_s3} * 13'd60);
	assign ten_full = stat_s3.shown - ({3'd0, q10_s3} * 16'd10);

	always_ff @(posedge clk) begin
		if (en) begin
			disp_s4.minutes <= min_s3;
			disp_s4.seconds <= sec_full[5:0];
			disp_s4.tenths  <= ten_full[3:0];
			disp_s4.up      <= stat_s3.up;
			disp_s4.run     <= stat_s3.run;
			disp_s4.pin     <= stat_s3.pin;
		end
	end

endmodule

// File: hw/rtl/up_down_stopwatch.sv
// Top level of the up/down stopwatch with preset: stream ports and pipeline control.
`timescale 1ns / 1ps

// Channel    Direction  Beat contents
// s_*        in         tuser: command (0 tick, 1 button sample); tdata: four button levels
// m_*        out        tdata: minutes, seconds, tenths, counting_up, is_running, pin_out
// cfg_*      in         preset_tenths, written when cfg_we is high
//
// Every beat passes four register stages: the input register, the state update, the
// reciprocal multiplies of the digit split and the remainder stage that feeds m_tdata.
// A beat is taken in every cycle in which s_tready is high.
// The whole pipeline moves together: while m_tvalid is high and m_tready is low, every
// stage holds and s_tready is low. Reset clears the state, the valid bits and the preset
// to 7200 tenths; the first beat can be taken in the first cycle after reset.

module up_down_stopwatch import usw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] btn_start_stop, [1] btn_reset, [2] btn_up,
	                               // [3] btn_down, [7:4] zero
	input  logic        s_tuser,   // [0] command
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [6:0] minutes, [12:7] seconds, [16:13] tenths,
	                               // [17] counting_up, [18] is_running, [19] pin_out,
	                               // [23:20] zero
	// Configuration.
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic  en;
	logic  valid_s1, valid_s2, valid_s3;
	item_t item_s1;
	ctl_t  ctl;
	stat_t stat_s2;
	disp_t disp_s4;

	// The pipeline advances whenever the output register is empty or being emptied.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			m_tvalid <= valid_s3;
		end
	end

	// Input register: payload needs no reset.
	always_ff @(posedge clk) begin
		if (en && s_tvalid) begin
			item_s1.command <= s_tuser;
			item_s1.btn     <= s_tdata[3:0];
		end
	end

	assign ctl.en    = en;
	assign ctl.valid = valid_s1;

	usw_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.item      (item_s1),
		.stat_s2   (stat_s2)
	);

	usw_split u_split (
		.clk     (clk),
		.en      (en),
		.stat_s2 (stat_s2),
		.disp_s4 (disp_s4)
	);

	assign m_tdata = {4'd0, disp_s4.pin, disp_s4.run, disp_s4.up,
	                  disp_s4.tenths, disp_s4.seconds, disp_s4.minutes};

endmodule
